// ===== sv/utf8v_pkg.sv =====
// Shared types, widths and byte constants for the UTF-8 string validator.
package utf8v_pkg;

    localparam int DATA_W   = 8;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 16;
    localparam int COUNT_W  = 17;
    localparam int CP_W     = 21;
    localparam int PEND_W   = 2;

    localparam logic [COUNT_W-1:0] COUNT_SAT   = 17'h10000;
    localparam logic [LEN_W-1:0]   LEN_RESET   = 16'hFFFF;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_UTF8 = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CTRL     = 2'd3;

    // Byte classes
    localparam logic [DATA_W-1:0] CTRL_MAX    = 8'h1F;
    localparam logic [DATA_W-1:0] DEL_BYTE    = 8'h7F;
    localparam logic [DATA_W-1:0] C2_BYTE     = 8'hC2;
    localparam logic [DATA_W-1:0] C1_LOW      = 8'h80;
    localparam logic [DATA_W-1:0] C1_HIGH     = 8'h9F;
    localparam logic [DATA_W-1:0] LEAD2_MASK  = 8'hE0;
    localparam logic [DATA_W-1:0] LEAD2_VAL   = 8'hC0;
    localparam logic [DATA_W-1:0] LEAD3_MASK  = 8'hF0;
    localparam logic [DATA_W-1:0] LEAD3_VAL   = 8'hE0;
    localparam logic [DATA_W-1:0] LEAD4_MASK  = 8'hF8;
    localparam logic [DATA_W-1:0] LEAD4_VAL   = 8'hF0;

    // Code point limits
    localparam logic [CP_W-1:0] CP_MIN2     = 21'h00080;
    localparam logic [CP_W-1:0] CP_MIN3     = 21'h00800;
    localparam logic [CP_W-1:0] CP_MIN4     = 21'h10000;
    localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h0D800;
    localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h0DFFF;
    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;

    // Continuation byte counts of a sequence
    localparam logic [PEND_W-1:0] SEQ_NONE = 2'd0;
    localparam logic [PEND_W-1:0] SEQ_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] SEQ_TWO  = 2'd2;
    localparam logic [PEND_W-1:0] SEQ_THREE = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              is_last;
        logic              empty_string;
    } item_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// ===== sv/utf8v_byte_if.sv =====
// Input channel carrying one string byte per word.
interface utf8v_byte_if import utf8v_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              is_last;
    logic              empty_string;

    modport source (output valid, output data_byte, output is_last, output empty_string,
                    input ready);
    modport sink   (input valid, input data_byte, input is_last, input empty_string,
                    output ready);
endinterface

// ===== sv/utf8v_status_if.sv =====
// Output channel carrying one string status per word.
interface utf8v_status_if import utf8v_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

// ===== sv/utf8v_cfg_if.sv =====
// Configuration write channel carrying the length limit.
interface utf8v_cfg_if import utf8v_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] max_length;

    modport source (output valid, output max_length, input ready);
    modport sink   (input valid, input max_length, output ready);
endinterface

// ===== sv/utf8v_step.sv =====
// Per-byte UTF-8 decode, control scan, length count and end-of-string status.
module utf8v_step import utf8v_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  item_t            item,
    input  logic [LEN_W-1:0] max_length,
    output result_t          res
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [PEND_W-1:0]  pend_reg, pend_next;
    logic [PEND_W-1:0]  seq_reg, seq_next;
    logic [CP_W-1:0]    cp_reg, cp_next;
    logic               utf8_bad_reg, utf8_bad_next;
    logic               ctrl_bad_reg, ctrl_bad_next;
    logic               prev_c2_reg, prev_c2_next;
    logic               str_end;

    // Decode one byte against the running sequence state
    always_comb
    begin
        logic [DATA_W-1:0] b;
        logic [CP_W-1:0]   cp_shift;
        logic [PEND_W-1:0] pend_dec;
        b        = item.data_byte;
        cp_shift = {cp_reg[CP_W-7:0], b[5:0]};
        pend_dec = pend_reg - 2'd1;

        count_next    = (count_reg < COUNT_SAT) ? count_reg + 17'd1 : count_reg;
        pend_next     = pend_reg;
        seq_next      = seq_reg;
        cp_next       = cp_reg;
        utf8_bad_next = utf8_bad_reg;

        if (!utf8_bad_reg)
        begin
            if (pend_reg == SEQ_NONE)
            begin
                priority if (!b[7])
                begin
                    pend_next = SEQ_NONE;
                end
                else if ((b & LEAD2_MASK) == LEAD2_VAL)
                begin
                    seq_next  = SEQ_ONE;
                    pend_next = SEQ_ONE;
                    cp_next   = {16'd0, b[4:0]};
                end
                else if ((b & LEAD3_MASK) == LEAD3_VAL)
                begin
                    seq_next  = SEQ_TWO;
                    pend_next = SEQ_TWO;
                    cp_next   = {17'd0, b[3:0]};
                end
                else if ((b & LEAD4_MASK) == LEAD4_VAL)
                begin
                    seq_next  = SEQ_THREE;
                    pend_next = SEQ_THREE;
                    cp_next   = {18'd0, b[2:0]};
                end
                else
                begin
                    utf8_bad_next = 1'b1;
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                utf8_bad_next = 1'b1;
                pend_next     = SEQ_NONE;
            end
            else
            begin
                cp_next   = cp_shift;
                pend_next = pend_dec;
                // Reject overlong, surrogate and out-of-range code points
                if (pend_dec == SEQ_NONE &&
                    ((seq_reg == SEQ_ONE   && cp_shift < CP_MIN2) ||
                     (seq_reg == SEQ_TWO   && cp_shift < CP_MIN3) ||
                     (seq_reg == SEQ_THREE && cp_shift < CP_MIN4) ||
                     (cp_shift >= CP_SURR_LO && cp_shift <= CP_SURR_HI) ||
                     cp_shift > CP_MAX))
                begin
                    utf8_bad_next = 1'b1;
                end
            end
        end

        // Scan raw bytes for controls, DEL and the C2 80..9F pair
        ctrl_bad_next = ctrl_bad_reg || (b <= CTRL_MAX) || (b == DEL_BYTE) ||
                        (prev_c2_reg && b >= C1_LOW && b <= C1_HIGH);
        prev_c2_next  = (b == C2_BYTE);
    end

    assign str_end = item.empty_string || item.is_last;

    // Pick the end-of-string status by priority
    always_comb
    begin
        res.valid = go && str_end;
        priority if (item.empty_string)
            res.status = ST_OK;
        else if (count_next > {1'b0, max_length})
            res.status = ST_TOO_LONG;
        else if (utf8_bad_next || pend_next != SEQ_NONE)
            res.status = ST_BAD_UTF8;
        else if (ctrl_bad_next)
            res.status = ST_CTRL;
        else
            res.status = ST_OK;
    end

    // Advance the string state, clear it when a string ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            pend_reg     <= SEQ_NONE;
            seq_reg      <= SEQ_NONE;
            cp_reg       <= '0;
            utf8_bad_reg <= 1'b0;
            ctrl_bad_reg <= 1'b0;
            prev_c2_reg  <= 1'b0;
        end
        else if (go)
        begin
            if (str_end)
            begin
                count_reg    <= '0;
                pend_reg     <= SEQ_NONE;
                seq_reg      <= SEQ_NONE;
                cp_reg       <= '0;
                utf8_bad_reg <= 1'b0;
                ctrl_bad_reg <= 1'b0;
                prev_c2_reg  <= 1'b0;
            end
            else
            begin
                count_reg    <= count_next;
                pend_reg     <= pend_next;
                seq_reg      <= seq_next;
                cp_reg       <= cp_next;
                utf8_bad_reg <= utf8_bad_next;
                ctrl_bad_reg <= ctrl_bad_next;
                prev_c2_reg  <= prev_c2_next;
            end
        end
    end

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (go && str_end) |=> (count_reg == '0 && pend_reg == SEQ_NONE &&
                             !utf8_bad_reg && !ctrl_bad_reg && !prev_c2_reg))
        else $error("string state not cleared after string end");

    a_bad_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        utf8_bad_reg |-> (pend_reg == SEQ_NONE))
        else $error("continuation still pending after UTF-8 error");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (go && !str_end && count_reg < COUNT_SAT) |=>
            (count_reg == $past(count_reg) + 17'd1))
        else $error("byte count did not advance");

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_SAT)
        else $error("byte count beyond saturation");

endmodule

// ===== sv/utf8v_result_stage.sv =====
// Result register between the decode step and the status channel.
module utf8v_result_stage import utf8v_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  result_t       res,
    output logic          space,
    utf8v_status_if.source result
);

    logic                valid_reg;
    logic [STATUS_W-1:0] status_reg;

    // Accept a new word when empty or when the held word leaves
    assign space        = !valid_reg || result.ready;
    assign result.valid = valid_reg;
    assign result.status = status_reg;

    // Hold the status until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (space)
            valid_reg <= res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (space && res.valid)
            status_reg <= res.status;
    end

endmodule

// ===== sv/utf8_string_validator.sv =====
// Top level: input register, per-byte step, result register and length limit.
// Output: a string's status is registered once its last byte has been stepped.
// Throughput: one byte per cycle while the status channel takes results;
//   the combinational decode step between the input and result registers sets this.
// Reset: rst_n clears all string state and both stages; the limit returns to 65535.
module utf8_string_validator import utf8v_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    utf8v_byte_if.sink     bytes,
    utf8v_status_if.source result,
    utf8v_cfg_if.sink      cfg
);

    logic [LEN_W-1:0] max_length_reg;
    item_t            item_reg;
    logic             item_valid_reg;
    logic             space;
    logic             go;
    result_t          res;

    assign cfg.ready   = 1'b1;
    assign go          = item_valid_reg && space;
    assign bytes.ready = !item_valid_reg || go;

    // Write the length limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_length_reg <= LEN_RESET;
        else if (cfg.valid)
            max_length_reg <= cfg.max_length;
    end

    // Capture the incoming word, drop it once stepped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (bytes.valid && bytes.ready)
            item_valid_reg <= 1'b1;
        else if (go)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            item_reg.data_byte    <= bytes.data_byte;
            item_reg.is_last      <= bytes.is_last;
            item_reg.empty_string <= bytes.empty_string;
        end
    end

    utf8v_step u_step
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .item       (item_reg),
        .max_length (max_length_reg),
        .res        (res)
    );

    utf8v_result_stage u_result
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .res    (res),
        .space  (space),
        .result (result)
    );

    a_empty_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (go && item_reg.empty_string) |=> (result.valid && result.status == ST_OK))
        else $error("empty string did not give ok");

    a_mid_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (go && !item_reg.empty_string && !item_reg.is_last) |=> !result.valid)
        else $error("result produced for a middle byte");

    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !space) |=> (item_valid_reg && $stable(item_reg)))
        else $error("input word lost while result stage full");

endmodule
